@@ hdl/tsl_pkg.sv @@
package tsl_pkg;

  // Size of the pattern list and of the removed-entry stack.
  localparam int unsigned PatternMax = 64;
  localparam int unsigned AddrW      = $clog2(PatternMax);
  localparam int unsigned CntW       = AddrW + 1;

  // Fixed field widths.
  localparam int unsigned CharW  = 8;
  localparam int unsigned DepthW = 6;
  localparam int unsigned LenW   = 7;

  // Entries beyond the active repeat that the list always carries.
  localparam int unsigned TailSlack = 3;
  localparam int unsigned MinLength = 4;
  localparam logic [LenW-1:0] LengthReset = 7'd16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIXEL = 2'd2
  } tsl_op_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_SHRINK = 2'd2
  } tsl_err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UNIT,
    S_PUSH,
    S_RM_CHK,
    S_RM_WR,
    S_INS_CHK,
    S_INS_WR,
    S_EMIT
  } tsl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // rearm for a new line
    logic load;       // write a pattern character
    logic px_begin;   // take a pixel beat, step the position
    logic skip_rise;  // rise unit skipped, list too short
    logic skip_fall;  // fall units dropped, stack empty
    logic rd_top;     // read the entry at the position
    logic push;       // push that entry onto the stack
    logic rm_read;    // read the entry after the index
    logic rm_write;   // move it down one place
    logic rm_done;    // close a removal
    logic pop_read;   // pop the stack top
    logic ins_read;   // read the entry before the index
    logic ins_write;  // move it up one place
    logic ins_done;   // place the popped entry after the position
    logic fetch;      // read the character to emit
    logic emit;       // load the output register
  } tsl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic rise;
    logic active_le1;
    logic stack_empty;
    logic rm_more;
    logic ins_more;
    logic out_free;
  } tsl_stat_t;

endpackage

@@ hdl/tsl_ram.sv @@
module tsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tsl_ctrl.sv @@
module tsl_ctrl
  import tsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  opcode_i,
  input  tsl_stat_t   stat_i,
  output logic        in_ready_o,
  output tsl_cmd_t    cmd_o
);

  tsl_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && tsl_op_e'(opcode_i) == OP_PIXEL) begin
          state_d = S_UNIT;
        end
      end
      S_UNIT: begin
        if (stat_i.cnt_zero) begin
          state_d = S_EMIT;
        end else if (stat_i.rise) begin
          if (!stat_i.active_le1) begin
            state_d = S_PUSH;
          end
        end else if (!stat_i.stack_empty) begin
          state_d = S_INS_CHK;
        end
      end
      S_PUSH:    state_d = S_RM_CHK;
      S_RM_CHK:  state_d = stat_i.rm_more ? S_RM_WR : S_UNIT;
      S_RM_WR:   state_d = S_RM_CHK;
      S_INS_CHK: state_d = stat_i.ins_more ? S_INS_WR : S_UNIT;
      S_INS_WR:  state_d = S_INS_CHK;
      S_EMIT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (tsl_op_e'(opcode_i))
            OP_START: cmd_o.start    = 1'b1;
            OP_LOAD:  cmd_o.load     = 1'b1;
            OP_PIXEL: cmd_o.px_begin = 1'b1;
            default:  ;
          endcase
        end
      end
      S_UNIT: begin
        if (stat_i.cnt_zero) begin
          cmd_o.fetch = 1'b1;
        end else if (stat_i.rise) begin
          if (stat_i.active_le1) begin
            cmd_o.skip_rise = 1'b1;
          end else begin
            cmd_o.rd_top = 1'b1;
          end
        end else if (stat_i.stack_empty) begin
          cmd_o.skip_fall = 1'b1;
        end else begin
          cmd_o.pop_read = 1'b1;
        end
      end
      S_PUSH: cmd_o.push = 1'b1;
      S_RM_CHK: begin
        if (stat_i.rm_more) begin
          cmd_o.rm_read = 1'b1;
        end else begin
          cmd_o.rm_done = 1'b1;
        end
      end
      S_RM_WR: cmd_o.rm_write = 1'b1;
      S_INS_CHK: begin
        if (stat_i.ins_more) begin
          cmd_o.ins_read = 1'b1;
        end else begin
          cmd_o.ins_done = 1'b1;
        end
      end
      S_INS_WR: cmd_o.ins_write = 1'b1;
      S_EMIT:   cmd_o.emit = stat_i.out_free;
      default:  ;
    endcase
  end

endmodule

@@ hdl/tsl_dpath.sv @@
module tsl_dpath
  import tsl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsl_cmd_t          cmd_i,
  output tsl_stat_t         stat_o,
  input  logic              cfg_we_i,
  input  logic [LenW-1:0]   cfg_data_i,
  input  logic [CharW-1:0]  pattern_char_i,
  input  logic [DepthW-1:0] pixel_depth_i,
  input  logic              last_in_line_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  out_char_o,
  output logic [1:0]        error_code_o
);

  // Control state.
  logic [LenW-1:0]   length_q, length_d;
  logic [CntW-1:0]   active_q, active_d;
  logic [CntW-1:0]   stack_cnt_q, stack_cnt_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [DepthW-1:0] prev_q, prev_d;
  logic [CntW-1:0]   load_ptr_q, load_ptr_d;
  logic              out_valid_q, out_valid_d;

  // Per-pixel working registers.
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [DepthW-1:0] cnt_q, cnt_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              last_q, last_d;
  logic              rise_q, rise_d;
  tsl_err_e          err_q, err_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  tsl_err_e          out_err_q, out_err_d;

  // Memory ports.
  logic              st_we, st_re, sk_we, sk_re;
  logic [AddrW-1:0]  st_waddr, st_raddr, sk_waddr, sk_raddr;
  logic [CharW-1:0]  st_wdata, st_rdata, sk_rdata;

  // Derived values.
  logic [CntW-1:0]   clamped;
  logic [CntW-1:0]   list_len;
  logic [CntW-1:0]   pos_nx;
  logic [AddrW-1:0]  pos_step;
  logic [AddrW-1:0]  pos_wrap;
  logic [CntW-1:0]   active_dec;
  logic [CntW-1:0]   stack_dec;
  logic [CntW-1:0]   idx_nx;
  logic [CntW-1:0]   pos_after;
  logic              out_free;

  // Register length clamped into the supported range.
  always_comb begin
    if (32'(length_q) < MinLength) begin
      clamped = CntW'(MinLength);
    end else if (32'(length_q) > PatternMax) begin
      clamped = CntW'(PatternMax);
    end else begin
      clamped = CntW'(length_q);
    end
  end

  assign list_len   = active_q + CntW'(TailSlack);
  assign pos_nx     = {1'b0, pos_q} + CntW'(1);
  assign pos_step   = (pos_nx >= active_q) ? '0 : pos_nx[AddrW-1:0];
  assign pos_wrap   = ({1'b0, pos_q} >= active_q) ? '0 : pos_q;
  assign active_dec = active_q - CntW'(1);
  assign stack_dec  = stack_cnt_q - CntW'(1);
  assign idx_nx     = {1'b0, idx_q} + CntW'(1);
  assign pos_after  = {1'b0, pos_q} + CntW'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  // Status towards the controller.
  always_comb begin
    stat_o.cnt_zero    = (cnt_q == '0);
    stat_o.rise        = rise_q;
    stat_o.active_le1  = (active_q <= CntW'(1));
    stat_o.stack_empty = (stack_cnt_q == '0);
    stat_o.rm_more     = (idx_nx < list_len);
    stat_o.ins_more    = ({1'b0, idx_q} > pos_after);
    stat_o.out_free    = out_free;
  end

  // Pattern list port selection.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx_q;
    st_wdata = st_rdata;
    st_re    = 1'b0;
    st_raddr = pos_q;
    if (cmd_i.load) begin
      st_we    = (load_ptr_q < CntW'(PatternMax));
      st_waddr = load_ptr_q[AddrW-1:0];
      st_wdata = pattern_char_i;
    end else if (cmd_i.rm_write || cmd_i.ins_write) begin
      st_we = 1'b1;
    end else if (cmd_i.ins_done) begin
      st_we    = 1'b1;
      st_waddr = pos_after[AddrW-1:0];
      st_wdata = sk_rdata;
    end
    if (cmd_i.rd_top) begin
      st_re = 1'b1;
    end else if (cmd_i.rm_read) begin
      st_re    = 1'b1;
      st_raddr = idx_nx[AddrW-1:0];
    end else if (cmd_i.ins_read) begin
      st_re    = 1'b1;
      st_raddr = idx_q - AddrW'(1);
    end else if (cmd_i.fetch) begin
      st_re    = 1'b1;
      st_raddr = pos_wrap;
    end
  end

  // Removed-entry stack port selection.
  assign sk_we    = cmd_i.push;
  assign sk_waddr = stack_cnt_q[AddrW-1:0];
  assign sk_re    = cmd_i.pop_read;
  assign sk_raddr = stack_dec[AddrW-1:0];

  // Next control state.
  always_comb begin
    length_d    = length_q;
    active_d    = active_q;
    stack_cnt_d = stack_cnt_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    load_ptr_d  = load_ptr_q;
    out_valid_d = out_valid_q;
    if (cfg_we_i) begin
      length_d = cfg_data_i;
    end
    if (cmd_i.start) begin
      active_d    = clamped - CntW'(TailSlack);
      stack_cnt_d = '0;
      pos_d       = '0;
      prev_d      = '0;
      load_ptr_d  = '0;
    end
    if (cmd_i.load && load_ptr_q < CntW'(PatternMax)) begin
      load_ptr_d = load_ptr_q + CntW'(1);
    end
    if (cmd_i.px_begin) begin
      pos_d = pos_step;
    end
    if (cmd_i.push) begin
      stack_cnt_d = stack_cnt_q + CntW'(1);
    end
    if (cmd_i.rm_done) begin
      active_d = active_dec;
      if ({1'b0, pos_q} >= active_dec) begin
        pos_d = '0;
      end
    end
    if (cmd_i.pop_read) begin
      stack_cnt_d = stack_dec;
    end
    if (cmd_i.ins_done) begin
      active_d = active_q + CntW'(1);
    end
    if (cmd_i.fetch) begin
      pos_d  = pos_wrap;
      prev_d = depth_q;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Next working and output payload.
  always_comb begin
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    depth_d    = depth_q;
    last_d     = last_q;
    rise_d     = rise_q;
    err_d      = err_q;
    out_char_d = out_char_q;
    out_err_d  = out_err_q;
    if (cmd_i.px_begin) begin
      depth_d = pixel_depth_i;
      last_d  = last_in_line_i;
      rise_d  = (pixel_depth_i > prev_q);
      cnt_d   = (pixel_depth_i > prev_q) ? (pixel_depth_i - prev_q)
                                         : (prev_q - pixel_depth_i);
      err_d   = ERR_NONE;
    end
    if (cmd_i.skip_rise) begin
      err_d = ERR_SHRINK;
      cnt_d = cnt_q - DepthW'(1);
    end
    if (cmd_i.skip_fall) begin
      err_d = ERR_EMPTY;
      cnt_d = '0;
    end
    if (cmd_i.push) begin
      idx_d = pos_q;
    end
    if (cmd_i.rm_write) begin
      idx_d = idx_q + AddrW'(1);
    end
    if (cmd_i.rm_done || cmd_i.ins_done) begin
      cnt_d = cnt_q - DepthW'(1);
    end
    if (cmd_i.pop_read) begin
      idx_d = list_len[AddrW-1:0];
    end
    if (cmd_i.ins_write) begin
      idx_d = idx_q - AddrW'(1);
    end
    if (cmd_i.emit) begin
      out_char_d = (active_q != '0 && !last_q) ? st_rdata : '0;
      out_err_d  = err_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= LengthReset;
      active_q    <= '0;
      stack_cnt_q <= '0;
      pos_q       <= '0;
      prev_q      <= '0;
      load_ptr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      length_q    <= length_d;
      active_q    <= active_d;
      stack_cnt_q <= stack_cnt_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      load_ptr_q  <= load_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    depth_q    <= depth_d;
    last_q     <= last_d;
    rise_q     <= rise_d;
    err_q      <= err_d;
    out_char_q <= out_char_d;
    out_err_q  <= out_err_d;
  end

  tsl_ram #(
    .Width (CharW),
    .Depth (PatternMax)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tsl_ram #(
    .Width (CharW),
    .Depth (PatternMax)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (st_rdata),
    .re_i    (sk_re),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign error_code_o = out_err_q;

endmodule

@@ hdl/text_stereogram_line_generator.sv @@
// Text stereogram line generator.
// Input beats arrive on the s_axis channel; tuser carries the opcode (start
// line, load pattern character, pixel depth). A start beat rearms the line
// from the pattern_length register, load beats fill the pattern list, and
// each pixel beat gives one result beat on m_axis: the character in tdata
// and the error code in tuser. Start and load beats give no result. The cfg
// channel writes pattern_length, which is always ready and should only be
// written while the block is idle. A pixel passes the unit and emit states
// into the output register. Per unit of depth change, a removal reads the
// entry at the position, pushes it onto the stack and moves the entries
// after it down; an insertion pops the stack, moves entries up and puts the
// popped entry after the position. Skipped rise units and an empty stack are
// handled in the unit state. Each moved entry is read, then written back.
// Only one item is worked on at a time; s_axis_tready is high while the
// block waits for a beat.
// The result sits in an output register, so start and load beats are still
// taken while the receiver stalls; a further pixel waits at its end until
// the register is free. Reset empties the list and the stack, clears the
// output valid and sets pattern_length to 16; the memories need no clearing.
module text_stereogram_line_generator
  import tsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // [6:0] pattern_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] pattern_char, [13:8] pixel_depth
  input  logic        s_axis_tlast,   // last_in_line
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic [1:0]  m_axis_tuser    // [1:0] error_code
);

  tsl_cmd_t  cmd;
  tsl_stat_t stat;

  // The register write is taken in every cycle.
  assign cfg_ready = 1'b1;

  tsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tsl_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid && cfg_ready),
    .cfg_data_i     (cfg_data[LenW-1:0]),
    .pattern_char_i (s_axis_tdata[CharW-1:0]),
    .pixel_depth_i  (s_axis_tdata[CharW+DepthW-1:CharW]),
    .last_in_line_i (s_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_char_o     (m_axis_tdata),
    .error_code_o   (m_axis_tuser)
  );

endmodule
